// ----- hdl/tim_pkg.sv -----
// Shared types and constants for the three-channel median inactivity monitor.
// Used by tim_history, tim_activity and the top level; depends on nothing else.

package tim_pkg;

    localparam int CHANNELS      = 3;
    localparam int HIST_DEPTH    = 3;
    localparam int SAMPLE_FIELDS = 3;
    localparam int SAMPLE_W      = 12;
    localparam int TIME_W        = 32;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;

    localparam int SUM_W       = SAMPLE_W + ((CHANNELS > 1) ? $clog2(CHANNELS) : 0);
    localparam int RECIP_SHIFT = SUM_W + ((CHANNELS > 1) ? $clog2(CHANNELS) : 0) + 1;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(CHANNELS) - 64'd1) / 64'(CHANNELS));

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd500;
    localparam logic [TIME_W-1:0]   DELAY_RESET     = 32'd180000;

    localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_DELAY     = 3'd4;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    typedef logic [SAMPLE_W-1:0]              sample_t;
    typedef logic [TIME_W-1:0]                time_t;
    typedef sample_t [CHANNELS-1:0]           chan_vec_t;
    typedef sample_t [SAMPLE_FIELDS-1:0]      field_vec_t;
    typedef sample_t [HIST_DEPTH-1:0]         hist_t;

endpackage

// ----- hdl/three_channel_median_inactivity_monitor.sv -----
// Top level of the three-channel median filter with inactivity timeout.
// Depends on tim_pkg, tim_history and tim_activity.

// The block takes one request per clock cycle and returns its result in the next
// cycle from an output register, so it sustains one request per cycle while
// out_stall is low; the whole computation for a request sits between the
// history and time registers and the output register. A sample frame shifts
// the history; a sleep check updates the last-active time and decides sleep.
// Configuration writes are expected only while no request is in flight.

module three_channel_median_inactivity_monitor
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [tim_pkg::SAMPLE_W-1:0]  sample_fore,
    input  logic [tim_pkg::SAMPLE_W-1:0]  sample_mid,
    input  logic [tim_pkg::SAMPLE_W-1:0]  sample_heel,
    input  logic [tim_pkg::TIME_W-1:0]    now_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tim_pkg::SAMPLE_W-1:0]  median_fore,
    output logic [tim_pkg::SAMPLE_W-1:0]  median_mid,
    output logic [tim_pkg::SAMPLE_W-1:0]  median_heel,
    output logic [tim_pkg::SAMPLE_W-1:0]  average_newest,
    output logic                          sleep_request,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tim_pkg::ADDR_W-1:0]    paddr,
    input  logic [tim_pkg::DATA_W-1:0]    pwdata,
    output logic [tim_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic                 accept;
    logic                 cfg_write;
    tim_pkg::sample_t     threshold_reg;
    tim_pkg::time_t       delay_reg;
    tim_pkg::chan_vec_t   samples;
    tim_pkg::field_vec_t  fields;
    tim_pkg::chan_vec_t   newest;
    tim_pkg::field_vec_t  medians;
    tim_pkg::sample_t     average;
    logic                 sleep;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    tim_pkg::field_vec_t  medians_reg;
    tim_pkg::sample_t     average_reg;
    logic                 sleep_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= tim_pkg::THRESHOLD_RESET;
            delay_reg     <= tim_pkg::DELAY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr)
                tim_pkg::ADDR_THRESHOLD: threshold_reg <= pwdata[tim_pkg::SAMPLE_W-1:0];
                tim_pkg::ADDR_DELAY:     delay_reg     <= pwdata[tim_pkg::TIME_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            tim_pkg::ADDR_THRESHOLD: prdata = tim_pkg::DATA_W'(threshold_reg);
            tim_pkg::ADDR_DELAY:     prdata = tim_pkg::DATA_W'(delay_reg);
            default:                 prdata = '0;
        endcase
    end

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign fields = {sample_heel, sample_mid, sample_fore};

    genvar ch;
    generate
        for (ch = 0; ch < tim_pkg::CHANNELS; ch++)
        begin : g_sample
            if (ch < tim_pkg::SAMPLE_FIELDS)
            begin : g_field
                assign samples[ch] = fields[ch];
            end
            else
            begin : g_none
                assign samples[ch] = '0;
            end
        end
    endgenerate

    tim_history u_history
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .shift   (mode == tim_pkg::MODE_SAMPLE),
        .samples (samples),
        .newest  (newest),
        .medians (medians)
    );

    tim_activity u_activity
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .check         (mode == tim_pkg::MODE_CHECK),
        .newest        (newest),
        .now_ms        (now_ms),
        .threshold     (threshold_reg),
        .delay         (delay_reg),
        .average       (average),
        .sleep_request (sleep)
    );

    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            medians_reg <= medians;
            average_reg <= average;
            sleep_reg   <= sleep;
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_fore    = medians_reg[0];
    assign median_mid     = medians_reg[1];
    assign median_heel    = medians_reg[2];
    assign average_newest = average_reg;
    assign sleep_request  = sleep_reg;

    a_sample_no_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode == tim_pkg::MODE_SAMPLE) |=> !sleep_request)
        else $error("Sleep request raised on a sample frame.");

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("Input stalled with no result waiting.");

    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(accept))
        else $error("Result appeared without an accepted request.");

endmodule

// ----- hdl/tim_history.sv -----
// Per-channel three-deep sample history with median-of-three selection.
// Depends on tim_pkg.

module tim_history
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                shift,
    input  tim_pkg::chan_vec_t  samples,
    output tim_pkg::chan_vec_t  newest,
    output tim_pkg::field_vec_t medians
);

    function automatic tim_pkg::sample_t median3(input tim_pkg::sample_t a,
                                                 input tim_pkg::sample_t b,
                                                 input tim_pkg::sample_t c);
        tim_pkg::sample_t lo;
        tim_pkg::sample_t hi;
        begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (c <= lo)
            begin
                return lo;
            end
            else if (c >= hi)
            begin
                return hi;
            end
            return c;
        end
    endfunction

    tim_pkg::hist_t hist_reg  [tim_pkg::CHANNELS];
    tim_pkg::hist_t hist_next [tim_pkg::CHANNELS];

    genvar ch;
    generate
        for (ch = 0; ch < tim_pkg::CHANNELS; ch++)
        begin : g_chan
            always_comb
            begin
                if (shift)
                begin
                    hist_next[ch] = {hist_reg[ch][tim_pkg::HIST_DEPTH-2:0], samples[ch]};
                end
                else
                begin
                    hist_next[ch] = hist_reg[ch];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    hist_reg[ch] <= '0;
                end
                else if (load)
                begin
                    hist_reg[ch] <= hist_next[ch];
                end
            end

            assign newest[ch] = hist_next[ch][0];
        end

        for (ch = 0; ch < tim_pkg::SAMPLE_FIELDS; ch++)
        begin : g_median
            if (ch < tim_pkg::CHANNELS)
            begin : g_live
                assign medians[ch] = median3(hist_next[ch][0], hist_next[ch][1],
                                             hist_next[ch][2]);
            end
            else
            begin : g_absent
                assign medians[ch] = '0;
            end
        end
    endgenerate

endmodule

// ----- hdl/tim_activity.sv -----
// Average of the newest samples, last-active time and the sleep decision.
// Depends on tim_pkg.

module tim_activity
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               check,
    input  tim_pkg::chan_vec_t newest,
    input  tim_pkg::time_t     now_ms,
    input  tim_pkg::sample_t   threshold,
    input  tim_pkg::time_t     delay,
    output tim_pkg::sample_t   average,
    output logic               sleep_request
);

    logic [tim_pkg::SUM_W-1:0]                   sum;
    logic [tim_pkg::SUM_W+tim_pkg::RECIP_W-1:0]  product;
    tim_pkg::time_t                              last_active_reg;
    tim_pkg::time_t                              last_active_next;
    tim_pkg::time_t                              idle_time;

    always_comb
    begin
        sum = '0;
        for (int ch = 0; ch < tim_pkg::CHANNELS; ch++)
        begin
            sum = sum + tim_pkg::SUM_W'(newest[ch]);
        end
    end

    // Division by the channel count is a multiply by its scaled reciprocal.
    assign product = (tim_pkg::SUM_W + tim_pkg::RECIP_W)'(sum) *
                     (tim_pkg::SUM_W + tim_pkg::RECIP_W)'(tim_pkg::RECIP_MULT);
    assign average = product[tim_pkg::RECIP_SHIFT +: tim_pkg::SAMPLE_W];

    assign last_active_next = (check && (average > threshold)) ? now_ms : last_active_reg;
    assign idle_time        = now_ms - last_active_next;
    assign sleep_request    = check && (idle_time > delay);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_active_reg <= '0;
        end
        else if (load)
        begin
            last_active_reg <= last_active_next;
        end
    end

endmodule

// ----- sim/tim_result_checker.sv -----
// Result checker for the three-channel median inactivity monitor.
// Mirrors the filter and timeout state from the observed requests and writes.
// Depends on tim_pkg only.

module tim_result_checker
    import tim_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                mode,
    input  logic [SAMPLE_W-1:0] sample_fore,
    input  logic [SAMPLE_W-1:0] sample_mid,
    input  logic [SAMPLE_W-1:0] sample_heel,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [SAMPLE_W-1:0] median_fore,
    input  logic [SAMPLE_W-1:0] median_mid,
    input  logic [SAMPLE_W-1:0] median_heel,
    input  logic [SAMPLE_W-1:0] average_newest,
    input  logic                sleep_request,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                pready,
    output int                  failures,
    output int                  outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sample_t median_fore;
        sample_t median_mid;
        sample_t median_heel;
        sample_t average_newest;
        logic    sleep_request;
    } filter_result_t;

    sample_t        threshold;
    time_t          delay_ms;
    time_t          last_active;
    hist_t          history [CHANNELS];
    filter_result_t predicted_outputs [$];

    function automatic sample_t middle_of(sample_t a, sample_t b, sample_t c);
        sample_t lo;
        sample_t hi;
        sample_t capped;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        capped = (c < hi) ? c : hi;
        return (capped > lo) ? capped : lo;
    endfunction

    function automatic sample_t channel_median(int ch);
        if (ch >= CHANNELS)
        begin
            return '0;
        end
        return middle_of(history[ch][0], history[ch][1], history[ch][2]);
    endfunction

    function automatic sample_t newest_mean();
        int total;
        total = 0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            total += history[ch][0];
        end
        return sample_t'(total / CHANNELS);
    endfunction

    function automatic filter_result_t advance_monitor(logic m, field_vec_t fields, time_t now);
        filter_result_t r;
        sample_t        mean;
        sample_t        incoming;
        r.sleep_request = 1'b0;
        if (m == MODE_SAMPLE)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                incoming = (ch < SAMPLE_FIELDS) ? fields[ch] : '0;
                history[ch] = {history[ch][HIST_DEPTH-2:0], incoming};
            end
            mean = newest_mean();
        end
        else
        begin
            mean = newest_mean();
            if (mean > threshold)
            begin
                last_active = now;
            end
            r.sleep_request = (time_t'(now - last_active) > delay_ms);
        end
        r.median_fore    = channel_median(0);
        r.median_mid     = channel_median(1);
        r.median_heel    = channel_median(2);
        r.average_newest = mean;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : observe
        filter_result_t got;
        filter_result_t want;
        field_vec_t     fields;
        if (!rst_n)
        begin
            threshold   = THRESHOLD_RESET;
            delay_ms    = DELAY_RESET;
            last_active = '0;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                history[ch] = '0;
            end
            predicted_outputs.delete();
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_THRESHOLD)
                begin
                    threshold = pwdata[SAMPLE_W-1:0];
                end
                else if (paddr == ADDR_DELAY)
                begin
                    delay_ms = pwdata[TIME_W-1:0];
                end
            end
            if (in_valid && !in_stall)
            begin
                fields = {sample_heel, sample_mid, sample_fore};
                predicted_outputs.push_back(advance_monitor(mode, fields, now_ms));
            end
            if (out_valid && !out_stall)
            begin
                got = '{median_fore, median_mid, median_heel, average_newest, sleep_request};
                if (predicted_outputs.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("%0t: result with no request pending: %h", $realtime, got);
                    end
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (got !== want)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("%0t: mismatch med %h/%h/%h avg %h sleep %b",
                                     $realtime, want.median_fore, want.median_mid,
                                     want.median_heel, want.average_newest,
                                     want.sleep_request);
                            $display("%0t:      got med %h/%h/%h avg %h sleep %b",
                                     $realtime, got.median_fore, got.median_mid,
                                     got.median_heel, got.average_newest,
                                     got.sleep_request);
                        end
                    end
                end
            end
            outstanding = predicted_outputs.size();
        end
    end

    initial
    begin
        failures = 0;
        outstanding = 0;
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the simulation for the three-channel median inactivity monitor.
// Drives requests, register writes and output stalls; depends on tim_pkg,
// the monitor and tim_result_checker.

module testbench;
    import tim_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 8;
    localparam int CYCLE_LIMIT     = 200000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                mode = MODE_SAMPLE;
    logic [SAMPLE_W-1:0] sample_fore = '0;
    logic [SAMPLE_W-1:0] sample_mid = '0;
    logic [SAMPLE_W-1:0] sample_heel = '0;
    logic [TIME_W-1:0]   now_ms = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SAMPLE_W-1:0] median_fore;
    logic [SAMPLE_W-1:0] median_mid;
    logic [SAMPLE_W-1:0] median_heel;
    logic [SAMPLE_W-1:0] average_newest;
    logic                sleep_request;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int      failures;
    int      outstanding;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      cycle_count = 0;
    sample_t cur_threshold = THRESHOLD_RESET;
    time_t   cur_delay = DELAY_RESET;
    time_t   clock_ms = '0;

    three_channel_median_inactivity_monitor u_dut (.*);

    tim_result_checker u_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(logic m, sample_t f, sample_t md, sample_t h, time_t now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid    <= 1'b0;
            sample_fore <= sample_t'($urandom());
            now_ms      <= $urandom();
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        sample_fore <= f;
        sample_mid  <= md;
        sample_heel <= h;
        now_ms      <= now;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(logic [DATA_W-1:0] thr, logic [DATA_W-1:0] dly);
        drain();
        write_register(ADDR_THRESHOLD, thr);
        write_register(ADDR_DELAY, dly);
        cur_threshold = thr[SAMPLE_W-1:0];
        cur_delay = dly;
    endtask

    function automatic sample_t pick_sample();
        int v;
        case ($urandom_range(7))
            0: v = 0;
            1: v = 4095;
            2, 3: v = int'(cur_threshold) + int'($urandom_range(16)) - 8;
            default: v = int'($urandom_range(4095));
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        else if (v > 4095)
        begin
            v = 4095;
        end
        return sample_t'(v);
    endfunction

    task automatic send_random_request();
        longint span;
        if ($urandom_range(99) < 30)
        begin
            span = (cur_delay > 32'd4000000) ? 1000000 : longint'(cur_delay) / 2 + 3;
            if ($urandom_range(15) == 0)
            begin
                clock_ms = $urandom();
            end
            else
            begin
                clock_ms += time_t'($urandom_range(0, int'(span)));
            end
            send_request(MODE_CHECK, sample_t'($urandom()), sample_t'($urandom()),
                         sample_t'($urandom()), clock_ms);
        end
        else
        begin
            send_request(MODE_SAMPLE, pick_sample(), pick_sample(), pick_sample(), $urandom());
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(MODE_CHECK, 12'd0, 12'd0, 12'd0, 32'd0);
        send_request(MODE_CHECK, 12'd0, 12'd0, 12'd0, 32'd180000);
        send_request(MODE_CHECK, 12'd0, 12'd0, 12'd0, 32'd180001);
        repeat (3) send_request(MODE_SAMPLE, 12'hFFF, 12'hFFF, 12'hFFF, 32'd0);
        send_request(MODE_CHECK, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFF0);
        send_request(MODE_SAMPLE, 12'h000, 12'hFFF, 12'h000, 32'hFFFF_FFFF);
        send_request(MODE_SAMPLE, 12'hFFF, 12'h000, 12'hFFF, 32'd0);
        send_request(MODE_SAMPLE, 12'h000, 12'h000, 12'h000, 32'd0);
        send_request(MODE_CHECK, 12'd0, 12'd0, 12'd0, 32'h0000_0010);
        send_request(MODE_CHECK, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFF0 + 32'd180001);
        send_request(MODE_SAMPLE, 12'd500, 12'd500, 12'd500, 32'd0);
        send_request(MODE_CHECK, 12'd0, 12'd0, 12'd0, 32'h0010_0000);
        send_request(MODE_SAMPLE, 12'd503, 12'd500, 12'd500, 32'd0);
        send_request(MODE_CHECK, 12'd0, 12'd0, 12'd0, 32'h0010_0000);
        send_request(MODE_SAMPLE, 12'd502, 12'd500, 12'd500, 32'd0);
        send_request(MODE_CHECK, 12'd0, 12'd0, 12'd0, 32'h0010_0000 + 32'd180001);
        send_request(MODE_SAMPLE, 12'hAAA, 12'h555, 12'hFFF, 32'h5555_AAAA);
        send_request(MODE_CHECK, 12'hFFF, 12'hFFF, 12'hFFF, 32'hAAAA_5555);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: configure(32'd0, 32'd0);
                1: configure(32'd4095, 32'hFFFF_FFFF);
                2: configure(32'd500, 32'd180000);
                3: configure($urandom(), $urandom_range(5000));
                4: configure(32'd2047, 32'd1);
                5: configure($urandom_range(4095), $urandom());
                6: configure(32'd100, 32'd1000);
                default: configure(32'd3000, 32'd50);
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_request();
        end

        drain();
        if (failures == 0 && outstanding == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- three_channel_median_inactivity_monitor.f -----
hdl/tim_pkg.sv
hdl/tim_history.sv
hdl/tim_activity.sv
hdl/three_channel_median_inactivity_monitor.sv
sim/tim_result_checker.sv
sim/testbench.sv
